// File: design/spo2r_pkg.sv
// Shared types and constants for the SpO2 ratio estimator.
package spo2r_pkg;

   localparam int MaxWindow  = 4096;
   localparam int SampleBits = 16;
   localparam int CountBits  = $clog2(MaxWindow + 1);
   localparam int SumBits    = SampleBits + CountBits;

   localparam logic signed [23:0] CoefC3 = -24'sd2455324;
   localparam logic signed [23:0] CoefC2 = 24'sd3827559;
   localparam logic signed [23:0] CoefC1 = -24'sd2430034;
   localparam logic signed [23:0] CoefC0 = 24'sd6564175;
   localparam logic signed [47:0] Spo2LoQ16 = 48'sd5898240;
   localparam logic signed [47:0] Spo2HiQ16 = 48'sd6553600;

   // One finished window handed from the front end to the back end.
   typedef struct packed {
      logic signed [SumBits-1:0] sum;
      logic [CountBits-1:0]      count;
      logic [16:0]               ac;
      logic                      fallback;
   } win_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_MUL, BK_DIV, BK_ROUND, BK_POLY, BK_DONE
   } bk_state_type;

   // floor((x + 2^15) / 2^16), an arithmetic shift
   function automatic logic signed [47:0] rescale16(input logic signed [63:0] x);
      logic signed [63:0] y;
      y = (x + 64'sd32768) >>> 16;
      return y[47:0];
   endfunction

endpackage

// File: design/spo2r_if.sv
// Valid/ready channel interface carrying a payload.
interface spo2r_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/spo2r_front.sv
// Front end: accumulate window statistics and queue finished windows.
module spo2r_front import spo2r_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic signed [15:0]   in_sample,
   input  logic [15:0]          in_ac,
   input  logic [7:0]           in_peaks,
   input  logic [7:0]           in_valleys,
   input  logic                 in_last,
   output logic                 win_valid,
   input  logic                 win_ready,
   output win_type              win_data
);
   logic signed [SumBits-1:0]    sum_ff, sum_in;
   logic [CountBits-1:0]         cnt_ff, cnt_in;
   logic signed [SampleBits-1:0] max_ff, max_in, min_ff, min_in;
   win_type                      q_ff [2];
   logic [1:0]                   fill_ff;
   logic                         wp_ff, rp_ff;
   logic signed [SampleBits-1:0] s;
   logic                         take, acc, pop, fb;
   win_type                      w;

   assign s        = in_sample[SampleBits-1:0];
   assign in_ready = (fill_ff != 2'd2);
   assign take     = in_valid && in_ready;
   assign acc      = take && (cnt_ff < CountBits'(MaxWindow));
   assign pop      = win_valid && win_ready;
   assign win_valid = (fill_ff != 2'd0);
   assign win_data  = q_ff[rp_ff];

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      max_in = max_ff;
      min_in = min_ff;
      if (acc) begin
         sum_in = sum_ff + SumBits'(s);
         cnt_in = cnt_ff + 1'b1;
         if (s > max_ff) max_in = s;
         if (s < min_ff) min_in = s;
      end
      fb = !(in_peaks >= 8'd2 && in_valleys >= 8'd2);
      w.sum      = sum_in;
      w.count    = cnt_in;
      w.fallback = fb;
      if (fb) begin
         w.ac = (max_in >= min_in) ? 17'(18'(max_in) - 18'(min_in)) : 17'd0;
      end else begin
         w.ac = {1'b0, in_ac};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         cnt_ff  <= '0;
         max_ff  <= {1'b1, {(SampleBits-1){1'b0}}};
         min_ff  <= {1'b0, {(SampleBits-1){1'b1}}};
         fill_ff <= '0;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
      end else begin
         if (take && in_last) begin
            sum_ff <= '0;
            cnt_ff <= '0;
            max_ff <= {1'b1, {(SampleBits-1){1'b0}}};
            min_ff <= {1'b0, {(SampleBits-1){1'b1}}};
            q_ff[wp_ff] <= w;
            wp_ff <= ~wp_ff;
         end else begin
            sum_ff <= sum_in;
            cnt_ff <= cnt_in;
            max_ff <= max_in;
            min_ff <= min_in;
         end
         if (pop) rp_ff <= ~rp_ff;
         fill_ff <= fill_ff + {1'b0, take && in_last} - {1'b0, pop};
      end
   end
endmodule

// File: design/spo2r_back.sv
// Back end: divide AC*count by sum, evaluate the calibration cubic.
module spo2r_back import spo2r_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                win_valid,
   output logic                win_ready,
   input  win_type             win_data,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [14:0]         out_spo2,
   output logic signed [23:0]  out_ratio,
   output logic                out_valid_res,
   output logic                out_fallback
);
   localparam int NumBits = 17 + CountBits + 17;   // 2*ac*count*2^16
   localparam int DenBits = SumBits + 1;
   localparam int RemBits = DenBits + 1;

   bk_state_type state_ff, state_in;
   logic [NumBits-1:0]  num_ff, num_in;
   logic [DenBits-1:0]  den_ff, den_in;
   logic [RemBits-1:0]  rem_ff, rem_in;
   logic [NumBits-1:0]  quo_ff, quo_in;
   logic [$clog2(NumBits+1)-1:0] bit_ff, bit_in;
   logic                neg_ff, neg_in, vld_ff, vld_in, fb_ff, fb_in;
   logic [1:0]          step_ff, step_in;
   logic signed [23:0]  ratio_ff, ratio_in;
   logic signed [47:0]  t_ff, t_in;
   logic [14:0]         spo2_ff, spo2_in;
   logic [RemBits-1:0]  shifted;
   logic signed [47:0]  p, pc;
   logic [NumBits-1:0]  mag;
   logic [CountBits+16:0] prod;

   assign out_valid     = (state_ff == BK_DONE);
   assign out_spo2      = spo2_ff;
   assign out_ratio     = ratio_ff;
   assign out_valid_res = vld_ff;
   assign out_fallback  = fb_ff;
   assign win_ready     = (state_ff == BK_IDLE);

   always_comb begin
      state_in = state_ff;
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; quo_in = quo_ff;
      bit_in = bit_ff; neg_in = neg_ff; vld_in = vld_ff; fb_in = fb_ff;
      step_in = step_ff; ratio_in = ratio_ff; t_in = t_ff; spo2_in = spo2_ff;
      shifted = {rem_ff[RemBits-2:0], num_ff[NumBits-1]};
      mag = quo_ff;
      prod = win_data.ac * win_data.count;
      p = rescale16(64'(t_ff) * 64'(ratio_ff));
      pc = t_ff;
      case (state_ff)
         BK_IDLE: begin
            if (win_valid) begin
               fb_in  = win_data.fallback;
               vld_in = (win_data.count != '0) && (win_data.sum != '0);
               neg_in = win_data.sum < 0;
               den_in = neg_in ? DenBits'(-(DenBits'(win_data.sum)))
                               : DenBits'(win_data.sum);
               num_in = NumBits'({prod, 17'd0});
               spo2_in = '0; ratio_in = '0;
               state_in = vld_in ? BK_DIV : BK_DONE;
               rem_in = '0; quo_in = '0;
               bit_in = ($clog2(NumBits+1))'(NumBits);
            end
         end
         BK_DIV: begin
            // restoring divide of (num + den) by 2*den, one bit a beat after the setup
            if (bit_ff == ($clog2(NumBits+1))'(NumBits)) begin
               num_in = num_ff + NumBits'(den_ff);
               den_in = den_ff;
               bit_in = bit_ff - 1'b1;
               rem_in = '0;
            end else begin
               num_in = num_ff << 1;
               if (shifted >= {den_ff, 1'b0}) begin
                  rem_in = shifted - {den_ff, 1'b0};
                  quo_in = {quo_ff[NumBits-2:0], 1'b1};
               end else begin
                  rem_in = shifted;
                  quo_in = {quo_ff[NumBits-2:0], 1'b0};
               end
               bit_in = bit_ff - 1'b1;
               if (bit_ff == '0) state_in = BK_ROUND;
            end
         end
         BK_ROUND: begin
            if (neg_ff)
               ratio_in = (mag >= NumBits'(8388608)) ? -24'sd8388608 : -24'(mag);
            else
               ratio_in = (mag > NumBits'(8388607)) ? 24'sd8388607 : 24'(mag);
            t_in = 48'(CoefC3);
            step_in = 2'd0;
            state_in = BK_POLY;
         end
         BK_POLY: begin
            case (step_ff)
               2'd0: t_in = p + 48'(CoefC2);
               2'd1: t_in = p + 48'(CoefC1);
               2'd2: t_in = p + 48'(CoefC0);
               default: begin
                  if (pc < Spo2LoQ16) pc = Spo2LoQ16;
                  if (pc > Spo2HiQ16) pc = Spo2HiQ16;
                  pc = (pc + 48'sd128) >>> 8;
                  spo2_in = pc[14:0];
                  state_in = BK_DONE;
               end
            endcase
            step_in = step_ff + 1'b1;
         end
         BK_DONE: if (out_ready) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BK_IDLE;
      else state_ff <= state_in;
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in; quo_ff <= quo_in;
      bit_ff <= bit_in; neg_ff <= neg_in; vld_ff <= vld_in; fb_ff <= fb_in;
      step_ff <= step_in; ratio_ff <= ratio_in; t_ff <= t_in; spo2_ff <= spo2_in;
   end
endmodule

// File: design/ppg_spo2_ratio_estimator_unit.sv
// Top level of the SpO2 ratio-of-ratios estimator.
//  channel | dir | payload
//  req     | in  | sample, ac_in, peak_count, valley_count, last
//  rsp     | out | spo2, ratio, valid_res, used_fallback
// A sample beat is taken every cycle while the two-entry window queue has room.
// The back end divides with a setup step, then one quotient bit per cycle for 47
// bits, rounds and saturates the ratio, then runs the three Horner steps and the
// clamp before the result beat is offered; a zero-DC or empty window goes from
// idle straight to the result beat.
// Reset is synchronous and clears the accumulators, queue and back-end state.
// The front keeps accepting while the back end works or a result is held,
// until both queue entries hold finished windows.
module ppg_spo2_ratio_estimator_unit import spo2r_pkg::*; (
   input  logic clock,
   input  logic reset,
   spo2r_if.sink   req,
   spo2r_if.source rsp
);
   logic    win_valid, win_ready;
   win_type win_data;

   spo2r_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready),
      .in_sample(req.payload.sample), .in_ac(req.payload.ac_in),
      .in_peaks(req.payload.peak_count), .in_valleys(req.payload.valley_count),
      .in_last(req.payload.last),
      .win_valid, .win_ready, .win_data
   );

   spo2r_back u_back (
      .clock, .reset,
      .win_valid, .win_ready, .win_data,
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_spo2(rsp.payload.spo2), .out_ratio(rsp.payload.ratio),
      .out_valid_res(rsp.payload.valid_res), .out_fallback(rsp.payload.used_fallback)
   );
endmodule
